FILE: rtl/core/cmf_pkg.sv
// shared types, constants and register codes of the cross median filter
package cmf_pkg;

    // fixed widths of the configuration registers
    localparam int LEN_W = 11;
    localparam int CNT_W = 16;
    localparam int CFG_W = 16;

    // parameter defaults
    localparam int LINE_MAX_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 24;

    // register reset values
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

    // configuration register index
    typedef enum logic [0:0] {
        CFG_LINE_LENGTH = 1'b0,
        CFG_LINE_COUNT  = 1'b1
    } t_cfg_idx;

    // per-item scan position flags from the scan control
    typedef struct packed {
        logic ignore;      // padding inside the image, no effect
        logic first_line;  // line 0, only stored
        logic second_line; // line 1, no line above
        logic drain;       // padding line after the image
        logic eol;         // last pixel of the line
        logic at_start;    // first pixel of the line
    } t_scan_info;

endpackage

FILE: rtl/core/cross_median_filter_unit.sv
// top level of the five-point cross median filter over a pixel stream
//
//  channel   dir  handshake                  contents
//  s_axis    in   s_axis_tvalid/tready       tdata: pixel value; tuser: padding flag
//  m_axis    out  m_axis_tvalid/tready       tdata: filtered value; tlast: end of line;
//                                            tuser: end of image
//  cfg       in   i_cfg_we                   i_cfg_idx selects line length or line count
//
// one request per clock while the output is not stalled; a request is registered in the read
// stage (line store read), then its median goes into the output register
// results lag one line: a request of line r gives the result for line r-1
// reset clears counters and valid flags and loads the config reset values; line stores need no clearing
// a stalled output holds the output register, the read stage keeps one more
// request, and only then does s_axis_tready drop
module cross_median_filter_unit #(
    parameter int LINE_MAX   = cmf_pkg::LINE_MAX_DEF,
    parameter int PIXEL_BITS = cmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  cmf_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [cmf_pkg::CFG_W-1:0]         i_cfg_data,
    // pixel input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,  // pixel_value, zero fill
    input  logic [0:0]                        s_axis_tuser,  // is_padding
    // filtered output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]   m_axis_tdata,  // filtered_value, zero fill
    output logic                              m_axis_tlast,  // end_of_line
    output logic [0:0]                        m_axis_tuser   // end_of_image
);
    import cmf_pkg::*;

    localparam int POS_W   = $clog2(LINE_MAX);
    localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

    // configuration registers
    logic [LEN_W-1:0] r_line_length;
    logic [CNT_W-1:0] r_line_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_line_count  <= CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LEN_W-1:0];
                CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[CNT_W-1:0];
                default:         r_line_count  <= r_line_count;
            endcase
        end
    end

    // handshake and pipeline control
    logic                  s_fire, work, s1_move, s1_go;
    logic [PIXEL_BITS-1:0] in_pix;
    logic [POS_W-1:0]      pos, pos_next;
    t_scan_info            info;

    logic                  r_s1_valid, n_s1_valid;
    logic                  r_out_valid, n_out_valid;

    assign in_pix        = s_axis_tdata[PIXEL_BITS-1:0];
    assign s1_move       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign work          = s_fire && !info.ignore;
    assign s1_go         = r_s1_valid && s1_move;

    cmf_scan_ctrl #(
        .LINE_MAX (LINE_MAX)
    ) u_scan_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_length (r_line_length),
        .i_line_count  (r_line_count),
        .i_accept      (s_fire),
        .i_padding     (s_axis_tuser[0]),
        .o_pos         (pos),
        .o_pos_next    (pos_next),
        .o_info        (info)
    );

    // line stores: newer line is kept twice so center and right read together
    logic [PIXEL_BITS-1:0] q_center, q_right, q_older;
    logic [PIXEL_BITS-1:0] center, up, down, left, right, median;
    logic                  newer_we;

    assign newer_we = work && !info.drain;

    cmf_line_store #(
        .DEPTH (LINE_MAX),
        .WIDTH (PIXEL_BITS)
    ) u_newer_center (
        .i_clk   (i_clk),
        .i_we    (newer_we),
        .i_waddr (pos),
        .i_wdata (in_pix),
        .i_re    (work),
        .i_raddr (pos),
        .o_rdata (q_center)
    );

    cmf_line_store #(
        .DEPTH (LINE_MAX),
        .WIDTH (PIXEL_BITS)
    ) u_newer_right (
        .i_clk   (i_clk),
        .i_we    (newer_we),
        .i_waddr (pos),
        .i_wdata (in_pix),
        .i_re    (work),
        .i_raddr (pos_next),
        .o_rdata (q_right)
    );

    // read stage registers
    t_scan_info            r_s1_info;
    logic [POS_W-1:0]      r_s1_pos;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic                  r_s1_byp;
    logic [PIXEL_BITS-1:0] r_left;

    // older line entry is written back as the request leaves the read stage; forward it when the
    // next request reads the same entry (single-pixel lines)
    cmf_line_store #(
        .DEPTH (LINE_MAX),
        .WIDTH (PIXEL_BITS)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_pos),
        .i_wdata (center),
        .i_re    (work),
        .i_raddr (pos),
        .o_rdata (q_older)
    );

    assign n_s1_valid = (r_s1_valid && !s1_move) || (work && !info.first_line);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_s1_info <= info;
            r_s1_pos  <= pos;
            r_s1_pix  <= in_pix;
            r_s1_byp  <= r_s1_valid && (r_s1_pos == pos);
        end
        // left neighbor is the center of the last filtered pixel
        if (s1_go) begin
            r_left <= center;
        end
    end

    // cross window with border replacement
    assign center = q_center;
    assign up     = r_s1_info.second_line ? center : (r_s1_byp ? r_left : q_older);
    assign down   = r_s1_info.drain ? center : r_s1_pix;
    assign left   = r_s1_info.at_start ? center : r_left;
    assign right  = r_s1_info.eol ? center : q_right;

    cmf_median5 #(
        .WIDTH (PIXEL_BITS)
    ) u_median5 (
        .i_a      (center),
        .i_b      (up),
        .i_c      (down),
        .i_d      (left),
        .i_e      (right),
        .o_median (median)
    );

    // output register
    logic [PIXEL_BITS-1:0] r_out_data;
    logic                  r_out_eol, r_out_eoi;

    assign n_out_valid = s1_go || (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= median;
            r_out_eol  <= r_s1_info.eol;
            r_out_eoi  <= r_s1_info.eol && r_s1_info.drain;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = TDATA_W'(r_out_data);
    assign m_axis_tlast    = r_out_eol;
    assign m_axis_tuser[0] = r_out_eoi;

    // end of image only on the last pixel of a line
    a_eoi_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("end of image without end of line");

    // forwarding is only needed when a line holds a single pixel
    a_byp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        work && r_s1_valid && (r_s1_pos == pos) |-> info.at_start && info.eol)
        else $error("older line forward outside single-pixel line");

    // a stalled read stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_pos))
        else $error("read stage lost a stalled request");

    // a request leaving the read stage shows up at the output
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> m_axis_tvalid)
        else $error("filtered pixel did not reach the output");

endmodule

FILE: rtl/core/cmf_line_store.sv
// one line store: single write port, single registered read port
module cmf_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old entry on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cmf_median5.sv
// median of five unsigned values through a min/max network
module cmf_median5 #(
    parameter int WIDTH = 24
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_c,
    input  logic [WIDTH-1:0] i_d,
    input  logic [WIDTH-1:0] i_e,
    output logic [WIDTH-1:0] o_median
);

    function automatic logic [WIDTH-1:0] f_min(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y);
        return (x < y) ? x : y;
    endfunction

    function automatic logic [WIDTH-1:0] f_max(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y);
        return (x < y) ? y : x;
    endfunction

    logic [WIDTH-1:0] lo_ab, hi_ab, lo_cd, hi_cd;
    logic [WIDTH-1:0] f_lo, g_hi;

    // drop the smallest and the largest of the four values in two pairs, then median of three
    assign lo_ab = f_min(i_a, i_b);
    assign hi_ab = f_max(i_a, i_b);
    assign lo_cd = f_min(i_c, i_d);
    assign hi_cd = f_max(i_c, i_d);
    assign f_lo  = f_max(lo_ab, lo_cd);
    assign g_hi  = f_min(hi_ab, hi_cd);

    assign o_median = f_max(f_min(i_e, f_lo), f_min(f_max(i_e, f_lo), g_hi));

endmodule

FILE: rtl/core/cmf_scan_ctrl.sv
// scan position and line counters with border and drain decode
module cmf_scan_ctrl #(
    parameter int LINE_MAX = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cmf_pkg::LEN_W-1:0]   i_line_length,
    input  logic [cmf_pkg::CNT_W-1:0]   i_line_count,
    input  logic                        i_accept,
    input  logic                        i_padding,
    output logic [$clog2(LINE_MAX)-1:0] o_pos,
    output logic [$clog2(LINE_MAX)-1:0] o_pos_next,
    output cmf_pkg::t_scan_info         o_info
);
    import cmf_pkg::*;

    localparam int POS_W = $clog2(LINE_MAX);
    localparam int CMP_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_line, n_line;
    logic [CMP_W-1:0] len_ext, eff_len, pos_inc;
    logic [CNT_W-1:0] eff_cnt;
    t_scan_info       info;

    // clamp the registers into their working range
    assign len_ext = CMP_W'(i_line_length);
    always_comb begin
        priority if (len_ext == '0) begin
            eff_len = CMP_W'(1);
        end else if (len_ext > CMP_W'(LINE_MAX)) begin
            eff_len = CMP_W'(LINE_MAX);
        end else begin
            eff_len = len_ext;
        end
    end
    assign eff_cnt = (i_line_count == '0) ? CNT_W'(1) : i_line_count;

    assign pos_inc = CMP_W'(r_pos) + CMP_W'(1);

    always_comb begin
        info.drain       = (r_line >= eff_cnt);
        info.ignore      = i_padding && !info.drain;
        info.first_line  = (r_line == '0);
        info.second_line = (r_line == CNT_W'(1));
        info.eol         = (pos_inc >= eff_len);
        info.at_start    = (r_pos == '0);
    end

    always_comb begin
        n_pos  = r_pos;
        n_line = r_line;
        if (i_accept && !info.ignore) begin
            if (info.eol) begin
                n_pos  = '0;
                n_line = info.drain ? '0 : r_line + CNT_W'(1);
            end else begin
                n_pos  = POS_W'(pos_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_line <= '0;
        end else begin
            r_pos  <= n_pos;
            r_line <= n_line;
        end
    end

    assign o_pos      = r_pos;
    // right neighbor address, wraps only where it is never used
    assign o_pos_next = (r_pos == POS_W'(LINE_MAX - 1)) ? '0 : r_pos + POS_W'(1);
    assign o_info     = info;

endmodule

FILE: tb/sv/cross_median_watch.sv
// checker of the cross median filter: follows requests, predicts results and compares them
`timescale 1ns / 1ps
module cross_median_watch #(
    parameter int LINE_MAX   = 1024,
    parameter int PIXEL_BITS = 24,
    parameter int DATA_W     = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  cmf_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [cmf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [DATA_W-1:0]         s_axis_tdata,   // pixel_value, zero fill
    input  logic [0:0]                s_axis_tuser,   // is_padding
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [DATA_W-1:0]         m_axis_tdata,   // filtered_value, zero fill
    input  logic                      m_axis_tlast,   // end_of_line
    input  logic [0:0]                m_axis_tuser,   // end_of_image
    output int                        o_err_count,
    output int                        o_pending,
    output int                        o_result_count
);
    import cmf_pkg::*;

    typedef struct {
        logic [PIXEL_BITS-1:0] value;
        logic                  eol;
        logic                  eoi;
    } t_filtered_px;

    t_filtered_px          pending_medians[$];

    logic [LEN_W-1:0]      len_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PIXEL_BITS-1:0] prev_row [LINE_MAX];
    logic [PIXEL_BITS-1:0] curr_row [LINE_MAX];
    int unsigned           col;
    logic [CNT_W-1:0]      row;
    logic [PIXEL_BITS-1:0] left_px;

    function automatic logic [PIXEL_BITS-1:0] median_of_cross(
        input logic [PIXEL_BITS-1:0] a, b, c, d, e
    );
        logic [PIXEL_BITS-1:0] v [5];
        logic [PIXEL_BITS-1:0] t;
        v[0] = a; v[1] = b; v[2] = c; v[3] = d; v[4] = e;
        for (int i = 1; i < 5; i++)
            for (int j = i; j > 0; j--)
                if (v[j-1] > v[j]) begin
                    t      = v[j];
                    v[j]   = v[j-1];
                    v[j-1] = t;
                end
        return v[2];
    endfunction

    // one accepted pixel request: update the scan state, queue the result it causes
    task automatic advance_scan(input logic [PIXEL_BITS-1:0] pix, input logic pad);
        int unsigned           n_len;
        int unsigned           n_rows;
        int unsigned           p;
        logic                  drain;
        logic                  eol;
        logic [PIXEL_BITS-1:0] c, up, dn, lf, rt;
        t_filtered_px          r;
        n_len  = len_reg;
        if (n_len == 0) n_len = 1;
        if (n_len > LINE_MAX) n_len = LINE_MAX;
        n_rows = (cnt_reg == 0) ? 1 : cnt_reg;
        drain  = (row >= n_rows);
        // padding inside the image leaves everything as it is
        if (pad && !drain) return;
        p = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
        eol = (p + 1 >= n_len);
        if (row == 0) begin
            curr_row[p] = pix;
            if (eol) begin
                col = 0;
                row = 1;
            end else begin
                col = p + 1;
            end
            return;
        end
        c  = curr_row[p];
        up = (row == 1) ? c : prev_row[p];
        dn = drain ? c : pix;
        lf = (p == 0) ? c : left_px;
        rt = eol ? c : curr_row[p+1];
        r.value = median_of_cross(c, up, dn, lf, rt);
        r.eol   = eol;
        r.eoi   = eol && drain;
        pending_medians.push_back(r);
        prev_row[p] = c;
        if (!drain) curr_row[p] = pix;
        left_px = c;
        if (eol) begin
            col = 0;
            row = drain ? '0 : row + 1'b1;
        end else begin
            col = p + 1;
        end
    endtask

    task automatic check_result();
        t_filtered_px want;
        o_result_count++;
        if (pending_medians.size() == 0) begin
            o_err_count++;
            if (o_err_count <= 10)
                $display("unexpected result %h eol %0b eoi %0b with nothing pending",
                         m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            return;
        end
        want = pending_medians.pop_front();
        if (m_axis_tdata !== DATA_W'(want.value) || m_axis_tlast !== want.eol
                || m_axis_tuser[0] !== want.eoi) begin
            o_err_count++;
            if (o_err_count <= 10)
                $display({"mismatch on result %0d: expected %h eol %0b eoi %0b,",
                          " got %h eol %0b eoi %0b"},
                         o_result_count, want.value, want.eol, want.eoi,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg   = LEN_RESET;
            cnt_reg   = CNT_RESET;
            col       = 0;
            row       = '0;
            left_px   = '0;
            pending_medians.delete();
            o_pending = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LINE_LENGTH) len_reg = i_cfg_data[LEN_W-1:0];
                else                              cnt_reg = i_cfg_data[CNT_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_scan(s_axis_tdata[PIXEL_BITS-1:0], s_axis_tuser[0]);
            o_pending = pending_medians.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// testbench top of the cross median filter: clock, reset, pixel requests, output stalls, verdict
`timescale 1ns / 1ps
module tb;
    import cmf_pkg::*;

    localparam int LINE_MAX    = 1024;
    localparam int PIXEL_BITS  = 24;
    localparam int DATA_W      = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 1250;    // random requests wanted, ignored padding not counted
    localparam int SETTLE      = 6;       // margin for the two-stage pipe before a register write
    localparam int TAIL        = 20;      // quiet cycles at the end to catch stray results
    localparam int LONG_HOLD   = 300;     // output hold that backs the block up to its input
    localparam int CYCLE_LIMIT = 500000;

    // block inputs, all known from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    t_cfg_idx          i_cfg_idx     = CFG_LINE_LENGTH;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // pixel_value, zero fill
    logic [0:0]        s_axis_tuser  = 1'b0; // is_padding
    logic              m_axis_tready = 1'b0;

    // block outputs
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [DATA_W-1:0] m_axis_tdata;         // filtered_value, zero fill
    logic              m_axis_tlast;         // end_of_line
    logic [0:0]        m_axis_tuser;         // end_of_image

    // from the checker
    int err_count;
    int pending;
    int result_count;

    // idle mix of the current phase, in percent of cycles
    int   idle_pct  = 0;
    int   stall_pct = 0;

    // long output hold, kicked once by the stimulus
    logic hold_kick = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    int cycle_cnt  = 0;
    int pixel_reqs = 0;
    int rand_reqs  = 0;
    int image_cnt  = 0;

    cross_median_filter_unit #(
        .LINE_MAX   (LINE_MAX),
        .PIXEL_BITS (PIXEL_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    cross_median_watch #(
        .LINE_MAX   (LINE_MAX),
        .PIXEL_BITS (PIXEL_BITS),
        .DATA_W     (DATA_W)
    ) watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .o_err_count    (err_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold while the input keeps pushing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_kick && !hold_used) begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD;
            hold_used     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // four idle mixes: none, sender idle, receiver stalling, both a little
    task automatic set_mode(input int m);
        case (m)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 64; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    // wide random values, also ties, extremes and values apart only in the top bits
    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(3))
            0:       return PIXEL_BITS'($urandom);
            1:       return PIXEL_BITS'($urandom_range(3));
            2:       return $urandom_range(1) ? '1 : '0;
            default: return PIXEL_BITS'($urandom_range(7)) << (PIXEL_BITS - 3);
        endcase
    endfunction

    // one request: random idle cycles first, then hold it until the block takes it
    // tready is looked at on the falling edge, where nothing is moving
    task automatic push_item(input logic [PIXEL_BITS-1:0] pix, input logic pad);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(pix);
        s_axis_tuser  <= pad;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        pixel_reqs++;
    endtask

    // drop valid, let every expected result come out, then wait out the SETTLE margin
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] len_v, input logic [CFG_W-1:0] cnt_v);
        write_reg(CFG_LINE_LENGTH, len_v);
        write_reg(CFG_LINE_COUNT, cnt_v);
    endtask

    // a whole image plus its drain line; noise_pct mixes in ignored padding inside the
    // image and plain pixels inside the drain line
    task automatic send_image(input logic [CFG_W-1:0] len_v, input logic [CFG_W-1:0] cnt_v,
                              input int noise_pct, input bit counted);
        int unsigned n_len;
        int unsigned n_rows;
        n_len  = len_v[LEN_W-1:0];
        if (n_len == 0) n_len = 1;
        if (n_len > LINE_MAX) n_len = LINE_MAX;
        n_rows = (cnt_v == 0) ? 1 : cnt_v;
        for (int r = 0; r < n_rows; r++)
            for (int p = 0; p < n_len; p++) begin
                if ($urandom_range(99) < noise_pct) push_item(rand_pixel(), 1'b1);
                push_item(rand_pixel(), 1'b0);
                if (counted) rand_reqs++;
            end
        for (int p = 0; p < n_len; p++) begin
            push_item(rand_pixel(), ($urandom_range(99) < noise_pct) ? 1'b0 : 1'b1);
            if (counted) rand_reqs++;
        end
        image_cnt++;
    endtask

    initial begin
        logic [CFG_W-1:0] len_v;
        logic [CFG_W-1:0] cnt_v;
        int               phase;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x2 image with extreme pixels, padding inside the image
        // and a plain pixel inside the drain line
        set_mode(0);
        configure(16'd3, 16'd2);
        push_item(24'h000000, 1'b0);
        push_item(24'hFFFFFF, 1'b0);
        push_item(24'h5A5A5A, 1'b1);    // ignored
        push_item(24'hAAAAAA, 1'b0);
        push_item(24'h555555, 1'b0);
        push_item(24'h000001, 1'b0);
        push_item(24'h800000, 1'b0);
        push_item(24'h123456, 1'b1);    // drain line starts
        push_item(24'hFEDCBA, 1'b0);    // pixel in drain acts as padding
        push_item(24'h000000, 1'b1);

        // zero length and zero count act as one: a single-pixel image
        configure(16'd0, 16'd0);
        push_item(24'hFFFFFF, 1'b0);
        push_item(24'h000000, 1'b1);

        // largest count, then cut short mid-image: length shrinks in the middle of
        // line 2, then the count drops below the current line and forces the drain
        configure(16'd4, 16'hFFFF);
        repeat (10) push_item(rand_pixel(), 1'b0);
        write_reg(CFG_LINE_LENGTH, 16'hF802);  // upper bits are not part of the length
        push_item(rand_pixel(), 1'b0);         // position 2 now ends the line
        repeat (2) push_item(rand_pixel(), 1'b0);
        write_reg(CFG_LINE_COUNT, 16'd2);
        push_item(rand_pixel(), 1'b1);
        push_item(rand_pixel(), 1'b0);

        // random images, mostly small, cycling through the idle mixes
        phase = 0;
        while (rand_reqs < RAND_ITEMS) begin
            set_mode(phase % 4);
            len_v = CFG_W'($urandom_range(1, 12));
            if ($urandom_range(4) == 0) len_v = CFG_W'($urandom_range(13, 64));
            if ($urandom_range(9) == 0) len_v = '0;
            if ($urandom_range(1)) len_v[CFG_W-1:LEN_W] = (CFG_W-LEN_W)'($urandom_range(31));
            cnt_v = ($urandom_range(9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
            if (phase == 4) begin
                // long output hold on a busy image, sender never idle
                len_v = 16'd8;
                cnt_v = 16'd6;
            end
            configure(len_v, cnt_v);
            if (phase == 4) hold_kick <= 1'b1;
            repeat ($urandom_range(1, 2)) send_image(len_v, cnt_v, 6, 1'b1);
            phase++;
        end

        // drain out and watch a little longer for anything extra
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL) @(posedge i_clk);

        $display("run: %0d pixel requests, %0d generated images, %0d random phases",
                 pixel_reqs, image_cnt, phase);
        $display("run: %0d filtered results checked; lengths 0..64, counts 0..6, %0d-cycle hold",
                 result_count, LONG_HOLD);
        if (err_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cmf_pkg.sv
rtl/core/cmf_line_store.sv
rtl/core/cmf_median5.sv
rtl/core/cmf_scan_ctrl.sv
rtl/core/cross_median_filter_unit.sv
tb/sv/cross_median_watch.sv
tb/sv/tb.sv
